// ----- hw/rtl/bcc_pkg.sv -----
// shared types, constants and register codes for the button click classifier
package bcc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int THR_W         = 16;
  localparam int CNT_W         = 8;

  localparam logic [THR_W-1:0] SHORT_LIMIT_RST = 16'd400;
  localparam logic [THR_W-1:0] HOLD_START_RST  = 16'd1000;
  localparam logic [THR_W-1:0] HOLD_END_RST    = 16'd3000;
  localparam logic [CNT_W-1:0] REL_CNT_RST     = 8'd1;

  typedef enum logic [1:0] {
    REG_SHORT_LIMIT = 2'd0,
    REG_HOLD_START  = 2'd1,
    REG_HOLD_END    = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] short_click_limit;
    logic [THR_W-1:0] hold_start;
    logic [THR_W-1:0] hold_end;
  } thr_t;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic             pressed;
    logic             new_press;
    logic             new_release;
    logic             short_click;
    logic             long_click;
    logic             hold_click;
    logic             hold_pressing;
    logic [31:0]      hold_ticks;
    logic [31:0]      released_ticks;
    logic [CNT_W-1:0] release_total;
  } out_item_t;

endpackage

// ----- hw/rtl/bcc_cfg.sv -----
// threshold registers behind the apb-style configuration port
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output thr_t                  thr
);

  thr_t     thr_r, thr_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign thr        = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      case (idx)
        REG_SHORT_LIMIT: thr_nxt.short_click_limit = cfg_pwdata[THR_W-1:0];
        REG_HOLD_START:  thr_nxt.hold_start        = cfg_pwdata[THR_W-1:0];
        REG_HOLD_END:    thr_nxt.hold_end          = cfg_pwdata[THR_W-1:0];
        default:         thr_nxt                   = thr_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SHORT_LIMIT: cfg_prdata = CFG_DATA_W'(thr_r.short_click_limit);
      REG_HOLD_START:  cfg_prdata = CFG_DATA_W'(thr_r.hold_start);
      REG_HOLD_END:    cfg_prdata = CFG_DATA_W'(thr_r.hold_end);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.short_click_limit <= SHORT_LIMIT_RST;
      thr_r.hold_start        <= HOLD_START_RST;
      thr_r.hold_end          <= HOLD_END_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

// ----- hw/rtl/bcc_core.sv -----
// edge detection, duration tracking, click classification and result register
module bcc_core
  import bcc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  in_item_t  item,
  input  thr_t      thr,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                 level_r, level_nxt;
  logic [TIME_BITS-1:0] press_stamp_r, press_stamp_nxt;
  logic [TIME_BITS-1:0] rel_stamp_r, rel_stamp_nxt;
  logic [TIME_BITS-1:0] hold_len_r, hold_len_nxt;
  logic [TIME_BITS-1:0] rel_len_r, rel_len_nxt;
  logic [CNT_W-1:0]     rel_cnt_r, rel_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 fire, rise, fall;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] t_short, t_start, t_end;
  logic [THR_W-1:0]     low16;

  assign take      = !out_valid_r || !out_stall;
  assign fire      = item_valid && take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign now     = TIME_BITS'(item.now_time);
  assign t_short = TIME_BITS'(thr.short_click_limit);
  assign t_start = TIME_BITS'(thr.hold_start);
  assign t_end   = TIME_BITS'(thr.hold_end);

  assign rise = item.pin_level && !level_r;
  assign fall = !item.pin_level && level_r;

  always_comb begin
    level_nxt       = item.pin_level;
    press_stamp_nxt = rise ? now : press_stamp_r;
    rel_stamp_nxt   = fall ? now : rel_stamp_r;
    rel_cnt_nxt     = fall ? rel_cnt_r + CNT_W'(1) : rel_cnt_r;
    hold_len_nxt    = hold_len_r;
    rel_len_nxt     = rel_len_r;
    // time running backwards clamps the tracked duration to zero
    if (item.pin_level) begin
      hold_len_nxt = (now >= press_stamp_nxt) ? now - press_stamp_nxt : '0;
    end else begin
      rel_len_nxt = (now >= rel_stamp_nxt) ? now - rel_stamp_nxt : '0;
    end
  end

  assign low16 = hold_len_nxt[THR_W-1:0];

  always_comb begin
    out_data_nxt.pressed        = level_nxt;
    out_data_nxt.new_press      = rise;
    out_data_nxt.new_release    = fall;
    // on a release tick hold_len_nxt still holds the last pressed value
    out_data_nxt.short_click    = fall && (hold_len_nxt <= t_short);
    out_data_nxt.long_click     = fall && (hold_len_nxt > t_short) && (hold_len_nxt < t_start);
    out_data_nxt.hold_click     = fall && (hold_len_nxt >= t_start) && (hold_len_nxt <= t_end);
    out_data_nxt.hold_pressing  = level_nxt && (low16 > thr.hold_start)
                                  && (low16 <= thr.hold_end);
    out_data_nxt.hold_ticks     = 32'(hold_len_nxt);
    out_data_nxt.released_ticks = 32'(rel_len_nxt);
    out_data_nxt.release_total  = rel_cnt_nxt;
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= 1'b0;
      press_stamp_r <= '0;
      rel_stamp_r   <= '0;
      hold_len_r    <= '0;
      rel_len_r     <= '0;
      rel_cnt_r     <= REL_CNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        level_r       <= level_nxt;
        press_stamp_r <= press_stamp_nxt;
        rel_stamp_r   <= rel_stamp_nxt;
        hold_len_r    <= hold_len_nxt;
        rel_len_r     <= rel_len_nxt;
        rel_cnt_r     <= rel_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- hw/rtl/button_click_classifier.sv -----
// top level of the button click classifier
//
//  channel  direction  payload     handshake
//  in_      input      in_item_t   in_valid / in_stall
//  out_     output     out_item_t  out_valid / out_stall
//  cfg_     apb rd/wr  thresholds  cfg_psel / cfg_penable / cfg_pready
//
// one sample per cycle sustained while out_ is not stalled; a result reaches out_ through
// the input register, then the compare/subtract path into the result register
// synchronous active-low reset: button released, release count 1, thresholds 400/1000/3000
// a stalled result holds; the input register still takes one more sample behind it
module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_data_r;
  logic     take, in_xfer;
  thr_t     thr;

  assign in_stall = s1_valid_r && !take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
  end

  bcc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  bcc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_data_r),
    .thr        (thr),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- hw/rtl/bcc_checker.sv -----
// port-level checks for the button click classifier, bound to the top level
module bcc_checker
  import bcc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a press starts a fresh hold
  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_press |-> out_data.pressed && (out_data.hold_ticks == 32'd0))
    else $error("press edge without zero hold");

  // clicks are only reported on a release
  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.short_click || out_data.long_click || out_data.hold_click)
    |-> out_data.new_release && !out_data.pressed)
    else $error("click reported outside a release");

  // long click excludes both neighbors
  a_long_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.long_click && (out_data.short_click || out_data.hold_click)))
    else $error("long click overlaps another class");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/tb_button_click_classifier.sv -----
// testbench for the button click classifier: directed sample table, then random click streams
module tb_button_click_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } sample_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // travels with in_data so the monitor sees the row that belongs to each transfer
  bit        note_typed = 1'b0;
  out_item_t note_want  = '0;

  // shadow of the classifier state and thresholds
  logic        btn_down    = 1'b0;
  logic [31:0] press_at    = '0;
  logic [31:0] release_at  = '0;
  logic [31:0] hold_len    = '0;
  logic [31:0] idle_len    = '0;
  logic [7:0]  release_cnt = REL_CNT_RST;
  logic [15:0] lim_short      = SHORT_LIMIT_RST;
  logic [15:0] lim_hold_start = HOLD_START_RST;
  logic [15:0] lim_hold_end   = HOLD_END_RST;

  out_item_t   pending_reports [$];
  int          fail_count   = 0;
  int          samples_sent = 0;
  bit          calm_in      = 1'b0;
  bit          calm_out     = 1'b0;
  logic        last_pin     = 1'b0;
  logic [31:0] tick_now     = '0;

  // rows 0-4 start from reset with default thresholds, so their results are typed in
  sample_row_t press_table [25] = '{
    '{'{1'b0, 32'd0},   1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 8'd1}},
    '{'{1'b0, 32'd100}, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd100, 8'd1}},
    '{'{1'b1, 32'd200}, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd100, 8'd1}},
    '{'{1'b1, 32'd600}, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd400, 32'd100, 8'd1}},
    // hold exactly at the short limit
    '{'{1'b0, 32'd650}, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd400, 32'd0, 8'd2}},
    '{'{1'b1, 32'd1000},  1'b0, '0},
    '{'{1'b1, 32'd1401},  1'b0, '0},
    '{'{1'b0, 32'd1500},  1'b0, '0},
    '{'{1'b1, 32'd2000},  1'b0, '0},
    // one below hold start, still a long click
    '{'{1'b1, 32'd2999},  1'b0, '0},
    '{'{1'b0, 32'd3000},  1'b0, '0},
    '{'{1'b1, 32'd4000},  1'b0, '0},
    '{'{1'b1, 32'd5000},  1'b0, '0},
    '{'{1'b1, 32'd5001},  1'b0, '0},
    '{'{1'b1, 32'd7000},  1'b0, '0},
    '{'{1'b0, 32'd7001},  1'b0, '0},
    '{'{1'b1, 32'd8000},  1'b0, '0},
    '{'{1'b1, 32'd11001}, 1'b0, '0},
    '{'{1'b0, 32'd11002}, 1'b0, '0},
    // time running backwards while released, then while pressed
    '{'{1'b0, 32'd100},   1'b0, '0},
    '{'{1'b1, 32'd50},    1'b0, '0},
    '{'{1'b1, 32'd10},    1'b0, '0},
    '{'{1'b1, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{1'b0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{1'b0, 32'd0},     1'b0, '0}
  };

  button_click_classifier u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t classify_sample(input in_item_t s);
    out_item_t   r;
    logic        rise;
    logic        fall;
    logic [15:0] hold_lo;
    rise = 1'b0;
    fall = 1'b0;
    if (s.pin_level != btn_down) begin
      btn_down = s.pin_level;
      if (s.pin_level) begin
        press_at = s.now_time;
        rise     = 1'b1;
      end else begin
        release_at  = s.now_time;
        fall        = 1'b1;
        release_cnt = release_cnt + 8'd1;
      end
    end
    // durations clamp to zero when the clock goes backwards
    if (btn_down)
      hold_len = (s.now_time >= press_at) ? s.now_time - press_at : '0;
    else
      idle_len = (s.now_time >= release_at) ? s.now_time - release_at : '0;
    hold_lo = hold_len[15:0];
    r.pressed        = btn_down;
    r.new_press      = rise;
    r.new_release    = fall;
    r.short_click    = fall && (hold_len <= 32'(lim_short));
    r.long_click     = fall && (hold_len > 32'(lim_short))
                       && (hold_len < 32'(lim_hold_start));
    r.hold_click     = fall && (hold_len >= 32'(lim_hold_start))
                       && (hold_len <= 32'(lim_hold_end));
    r.hold_pressing  = btn_down && (hold_lo > lim_hold_start) && (hold_lo <= lim_hold_end);
    r.hold_ticks     = hold_len;
    r.released_ticks = idle_len;
    r.release_total  = release_cnt;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 200)
        $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_thresholds();
    logic [31:0] rd;
    apb_xfer(1'b0, REG_SHORT_LIMIT, '0, rd);
    check_field("short_click_limit", 32'(lim_short), 32'(rd[15:0]));
    apb_xfer(1'b0, REG_HOLD_START, '0, rd);
    check_field("hold_start", 32'(lim_hold_start), 32'(rd[15:0]));
    apb_xfer(1'b0, REG_HOLD_END, '0, rd);
    check_field("hold_end", 32'(lim_hold_end), 32'(rd[15:0]));
  endtask

  task automatic send_sample(input logic pin, input logic [31:0] t, input bit typed,
                             input out_item_t want);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= '{pin_level: pin, now_time: t};
    note_typed <= typed;
    note_want  <= want;
    last_pin = pin;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // pipeline is two deep; drain every pending report before going on
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t calc;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 200)
            $display("%0t ns: result %h with nothing expected", $time, out_data);
        end else begin
          want = pending_reports.pop_front();
          check_field("pressed", 32'(want.pressed), 32'(out_data.pressed));
          check_field("new_press", 32'(want.new_press), 32'(out_data.new_press));
          check_field("new_release", 32'(want.new_release), 32'(out_data.new_release));
          check_field("short_click", 32'(want.short_click), 32'(out_data.short_click));
          check_field("long_click", 32'(want.long_click), 32'(out_data.long_click));
          check_field("hold_click", 32'(want.hold_click), 32'(out_data.hold_click));
          check_field("hold_pressing", 32'(want.hold_pressing),
                      32'(out_data.hold_pressing));
          check_field("hold_ticks", want.hold_ticks, out_data.hold_ticks);
          check_field("released_ticks", want.released_ticks, out_data.released_ticks);
          check_field("release_total", 32'(want.release_total),
                      32'(out_data.release_total));
        end
      end
      if (in_valid && !in_stall) begin
        calc = classify_sample(in_data);
        pending_reports.push_back(note_typed ? note_want : calc);
      end
    end
  end

  // result side: random stall before each transfer, with calm stretches
  initial begin
    int hold_off;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
      hold_off = calm_out ? 0 : $urandom_range(0, 17);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int          ph;
    int          n;
    int          pick;
    int          goal;
    logic [31:0] dur;
    logic [31:0] stamp;
    logic [31:0] wd;
    logic [31:0] rd;
    logic [15:0] thr [3];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    verify_thresholds();

    foreach (press_table[i])
      send_sample(press_table[i].stim.pin_level, press_table[i].stim.now_time,
                  press_table[i].typed, press_table[i].want);
    wait_results_done();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          thr[0] = 16'($urandom_range(0, 2000));
          thr[1] = thr[0] + 16'($urandom_range(1, 3000));
          thr[2] = thr[1] + 16'($urandom_range(0, 5000));
        end
        1: thr = '{16'd0, 16'd0, 16'd0};
        2: thr = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        // thresholds out of order: classes overlap or go empty
        3: thr = '{16'd3000, 16'd800, 16'd200};
        4: begin
          thr[0] = 16'($urandom_range(0, 65535));
          thr[1] = 16'($urandom_range(0, 65535));
          thr[2] = 16'($urandom_range(0, 65535));
        end
        default: thr = '{SHORT_LIMIT_RST, HOLD_START_RST, HOLD_END_RST};
      endcase
      // upper data bits are junk; the fourth write goes to the unused slot
      for (int r = 0; r < 4; r++) begin
        wd = $urandom();
        if (r < 3) wd[15:0] = thr[r];
        apb_xfer(1'b1, reg_idx_t'(r), wd, rd);
      end
      lim_short      = thr[0];
      lim_hold_start = thr[1];
      lim_hold_end   = thr[2];
      verify_thresholds();

      goal = samples_sent + 90;
      while (samples_sent < goal) begin
        if ($urandom_range(0, 7) == 0) calm_in = !calm_in;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          // clean click with the hold landing on or beside a threshold, or at a random length
          case ($urandom_range(0, 6))
            0: dur = 32'(lim_short);
            1: dur = 32'(lim_hold_start);
            2: dur = 32'(lim_hold_end);
            3: dur = $urandom_range(0, 4000);
            4: dur = 32'h10000 + 32'(lim_hold_start) + $urandom_range(1, 200);
            5: dur = $urandom_range(0, 200000);
            default: dur = $urandom_range(0, 65535);
          endcase
          n = $urandom_range(0, 2);
          if (dur != 0) dur = dur + n - 1;
          else dur = n;
          tick_now = tick_now + $urandom_range(1, 300);
          stamp = tick_now;
          send_sample(1'b1, tick_now, 1'b0, '0);
          n = $urandom_range(0, 3);
          repeat (n) begin
            tick_now = tick_now + $urandom_range(0, stamp + dur - tick_now);
            send_sample(1'b1, tick_now, 1'b0, '0);
          end
          tick_now = stamp + dur;
          send_sample(1'b1, tick_now, 1'b0, '0);
          tick_now = tick_now + $urandom_range(0, 100);
          send_sample(1'b0, tick_now, 1'b0, '0);
          if ($urandom_range(0, 1) == 1) begin
            tick_now = tick_now + $urandom_range(0, 5000);
            send_sample(1'b0, tick_now, 1'b0, '0);
          end
        end else if (pick < 16) begin
          // contact bounce: every sample flips the level
          n = $urandom_range(10, 30);
          repeat (n) begin
            tick_now = tick_now + $urandom_range(0, 3);
            send_sample(!last_pin, tick_now, 1'b0, '0);
          end
        end else begin
          n = $urandom_range(1, 12);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: tick_now = $urandom();
              1: tick_now = tick_now - $urandom_range(0, 2000);
              2: tick_now = 32'hFFFF_F000 + $urandom_range(0, 4095);
              default: tick_now = tick_now + $urandom_range(0, 3000);
            endcase
            send_sample(1'($urandom_range(0, 1)), tick_now, 1'b0, '0);
          end
        end
        if ($urandom_range(0, 39) == 0) wait_results_done();
      end
      wait_results_done();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
